### hdl/assert_macros.svh
// Assertion macros for the skinning block.
// Needs a clk and an active-low arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/vsk_pkg.sv
// Shared types and constants for the four-bone skinning block.
// No dependencies.
`timescale 1ns / 1ps
package vsk_pkg;
	localparam int unsigned NUM_LANES = 4;
	localparam int unsigned WORDS_PER_BONE = 12;
	localparam int unsigned CW = 49;	// slot contribution width
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_VERTEX = 1'b1;
	localparam logic signed [63:0] ROW_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam logic signed [63:0] ROW_MIN = 64'shFFFF_8000_0000_0000;
	localparam logic signed [63:0] OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] OUT_MIN = 64'shFFFF_FFFF_8000_0000;

	typedef logic [2:0][31:0] vec3_t;

	// what one lane hands to the merge stage
	typedef struct packed {
		logic [2:0][CW-1:0] contrib;
		logic               sat;
	} lane_res_t;
endpackage

### hdl/vsk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module vsk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

### hdl/vsk_lane.sv
// One skinning lane: matrix store copy, 3x3 product rows, row clip, weighting.
// Depends on vsk_pkg and vsk_ram.
`timescale 1ns / 1ps
module vsk_lane #(
	parameter int MAX_BONES = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [vsk_pkg::WORDS_PER_BONE-1:0] wr_en,
	input  logic [(MAX_BONES > 1 ? $clog2(MAX_BONES) : 1)-1:0] wr_addr,
	input  logic [31:0]            wr_data,
	input  logic [(MAX_BONES > 1 ? $clog2(MAX_BONES) : 1)-1:0] rd_addr,
	input  logic                   live,
	input  logic [15:0]            weight,
	input  vsk_pkg::vec3_t         pos,
	output vsk_pkg::lane_res_t     res_s4
);
	logic [31:0] m_s1 [vsk_pkg::WORDS_PER_BONE];
	vsk_pkg::vec3_t pos_s1;
	logic [15:0] w_s1, w_s2, w_s3;
	logic live_s1, live_s2, live_s3;
	logic signed [63:0] prod_s2 [3][3];
	logic [31:0] trans_s2 [3];
	logic signed [47:0] t_s3 [3];
	logic rsat_s3;
	logic signed [47:0] t_d [3];
	logic rsat_d;

	// per-word copies of the matrix store, read by this lane's bone code
	for (genvar k = 0; k < vsk_pkg::WORDS_PER_BONE; k++) begin : g_word
		vsk_ram #(.WIDTH(32), .DEPTH(MAX_BONES)) u_ram (
			.clk  (clk),
			.we   (wr_en[k]),
			.waddr(wr_addr),
			.wdata(wr_data),
			.re   (en),
			.raddr(rd_addr),
			.rdata(m_s1[k])
		);
	end

	// stage 1: side data alongside the RAM read
	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1 <= pos;
			w_s1 <= weight;
		end
	end

	// stage 2: nine products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++)
					prod_s2[r][c] <= $signed(m_s1[4*r+c]) * $signed(pos_s1[c]);
				trans_s2[r] <= m_s1[4*r+3];
			end
			w_s2 <= w_s1;
		end
	end

	// row sums with translation, clipped to 48 bits
	always_comb begin
		logic signed [63:0] sum;
		rsat_d = 1'b0;
		for (int r = 0; r < 3; r++) begin
			sum = (prod_s2[r][0] >>> FRAC_BITS) + (prod_s2[r][1] >>> FRAC_BITS)
				+ (prod_s2[r][2] >>> FRAC_BITS)
				+ $signed({{32{trans_s2[r][31]}}, trans_s2[r]});
			if (sum > vsk_pkg::ROW_MAX) begin
				t_d[r] = vsk_pkg::ROW_MAX[47:0];
				rsat_d = 1'b1;
			end else if (sum < vsk_pkg::ROW_MIN) begin
				t_d[r] = vsk_pkg::ROW_MIN[47:0];
				rsat_d = 1'b1;
			end else begin
				t_d[r] = sum[47:0];
			end
		end
	end

	// stage 3
	always_ff @(posedge clk) begin
		if (en) begin
			t_s3 <= t_d;
			rsat_s3 <= rsat_d;
			w_s3 <= w_s2;
		end
	end

	// live flag travels with the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1 <= 1'b0;
			live_s2 <= 1'b0;
			live_s3 <= 1'b0;
		end else if (en) begin
			live_s1 <= live;
			live_s2 <= live_s1;
			live_s3 <= live_s2;
		end
	end

	// stage 4: weight and floor by 16 bits; dead slots add zero
	always_ff @(posedge clk) begin
		logic signed [64:0] wp;
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				wp = t_s3[r] * $signed({1'b0, w_s3});
				res_s4.contrib[r] <= live_s3 ? wp[64:16] : '0;
			end
			res_s4.sat <= live_s3 & rsat_s3;
		end
	end
endmodule

### hdl/vsk_merge.sv
// Merge stage: sums the lane contributions, final clip, output register.
// Depends on vsk_pkg.
`timescale 1ns / 1ps
module vsk_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid_s4,
	input  vsk_pkg::lane_res_t lane_res [vsk_pkg::NUM_LANES],
	output logic               valid_q,
	output vsk_pkg::vec3_t     data_q,
	output logic               sat_q
);
	vsk_pkg::vec3_t data_d;
	logic sat_d;

	// sum four slots per row and clip to 32 bits
	always_comb begin
		logic signed [63:0] acc;
		sat_d = 1'b0;
		for (int l = 0; l < vsk_pkg::NUM_LANES; l++)
			sat_d = sat_d | lane_res[l].sat;
		for (int r = 0; r < 3; r++) begin
			acc = '0;
			for (int l = 0; l < vsk_pkg::NUM_LANES; l++)
				acc = acc + $signed({{(64 - vsk_pkg::CW){lane_res[l].contrib[r][vsk_pkg::CW-1]}},
					lane_res[l].contrib[r]});
			if (acc > vsk_pkg::OUT_MAX) begin
				data_d[r] = vsk_pkg::OUT_MAX[31:0];
				sat_d = 1'b1;
			end else if (acc < vsk_pkg::OUT_MIN) begin
				data_d[r] = vsk_pkg::OUT_MIN[31:0];
				sat_d = 1'b1;
			end else begin
				data_d[r] = acc[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= data_d;
			sat_q <= sat_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en)
			valid_q <= valid_s4;
	end
endmodule

### hdl/vertex_skinning_four_bone.sv
// Four-bone linear blend skinning, one lane per bone slot.
// Vertex results pass stages s1-s4 and the merge output register; loads give none.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// A load written in one cycle is seen by a vertex request in the next.
// Reset clears the pipeline valid bits only; matrix words are undefined until loaded.
// Depends on vsk_pkg, vsk_lane, vsk_merge, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vertex_skinning_four_bone #(
	parameter int MAX_BONES = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// load_bone[4:0], load_entry[8:5], load_value[40:9], pos_x[72:41], pos_y[104:73],
	// pos_z[136:105], bone_slots[160:137], weight_slots[224:161], zero pad
	input  logic [231:0] s_axis_tdata,
	// req_type
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64]
	output logic [95:0]  m_axis_tdata,
	// saturated
	output logic         m_axis_tuser
);
	localparam int AW = MAX_BONES > 1 ? $clog2(MAX_BONES) : 1;

	logic en, accept;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [4:0] load_bone;
	logic [3:0] load_entry;
	logic [23:0] bone_slots;
	logic [63:0] weight_slots;
	vsk_pkg::vec3_t pos;
	logic [vsk_pkg::WORDS_PER_BONE-1:0] wr_en;
	vsk_pkg::lane_res_t lane_res [vsk_pkg::NUM_LANES];
	vsk_pkg::vec3_t data_q;

	assign load_bone    = s_axis_tdata[4:0];
	assign load_entry   = s_axis_tdata[8:5];
	assign pos[0]       = s_axis_tdata[72:41];
	assign pos[1]       = s_axis_tdata[104:73];
	assign pos[2]       = s_axis_tdata[136:105];
	assign bone_slots   = s_axis_tdata[160:137];
	assign weight_slots = s_axis_tdata[224:161];

	// global advance: hold everything while the output is stalled
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign accept = s_axis_tvalid && en;

	// word write enables for a load request in range
	always_comb begin
		for (int k = 0; k < vsk_pkg::WORDS_PER_BONE; k++)
			wr_en[k] = accept && (s_axis_tuser == vsk_pkg::REQ_LOAD)
				&& ({1'b0, load_bone} < 6'(MAX_BONES)) && (load_entry == 4'(k));
	end

	// vertex valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept && (s_axis_tuser == vsk_pkg::REQ_VERTEX);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// one lane per bone slot
	for (genvar l = 0; l < vsk_pkg::NUM_LANES; l++) begin : g_lane
		logic [5:0] code;
		logic [5:0] wr_bone;
		assign code = bone_slots[6*l +: 6];
		assign wr_bone = {1'b0, load_bone};
		vsk_lane #(.MAX_BONES(MAX_BONES), .FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.wr_en  (wr_en),
			.wr_addr(wr_bone[AW-1:0]),
			.wr_data(s_axis_tdata[40:9]),
			.rd_addr(code[AW-1:0]),
			.live   (code < 6'(MAX_BONES)),
			.weight (weight_slots[16*l +: 16]),
			.pos    (pos),
			.res_s4 (lane_res[l])
		);
	end

	vsk_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.valid_s4(v_s4),
		.lane_res(lane_res),
		.valid_q (m_axis_tvalid),
		.data_q  (data_q),
		.sat_q   (m_axis_tuser)
	);

	assign m_axis_tdata = data_q;

	`ASSERT_NEXT(a_load_no_result, accept && s_axis_tuser == vsk_pkg::REQ_LOAD, !v_s1, "load request entered the result pipeline")
	`ASSERT_NEXT(a_vertex_enters, accept && s_axis_tuser == vsk_pkg::REQ_VERTEX, v_s1, "vertex request lost at entry")
	`ASSERT_NEXT(a_stall_holds, !en, $stable(v_s4) && $stable(v_s1), "pipeline moved during a stall")
	`ASSERT_NOW(a_no_write_on_stall, !en, wr_en == '0, "matrix write while stalled")
endmodule
